// File: sv/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg
// shared types, constants and the arctangent table for the range-to-point block
// ----------------------------------------------------------------------------
package lrp_pkg;

   localparam int RANGE_W    = 20;
   localparam int COLUMN_W   = 11;
   localparam int ROW_W      = 7;
   localparam int ANGLE_W    = 16;
   localparam int INTENS_W   = 16;
   localparam int COORD_W    = 21;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int DEF_MAX_COLUMNS = 2048;
   localparam int DEF_MAX_ROWS    = 128;
   localparam int STAGES     = 16;
   localparam int CW         = 34;
   localparam int ZW         = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [CSR_ADDR_W-1:0] REG_HSTART = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_HSTEP  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_VSTART = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_VSTEP  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_RLOW   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_RHIGH  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_INTENS = 3'd6;

   typedef struct packed {
      logic [RANGE_W-1:0]  range_mm;
      logic [ANGLE_W-1:0]  h_angle;
      logic [ANGLE_W-1:0]  v_angle;
      logic [ROW_W-1:0]    row;
      logic                kept;
      logic                last;
      logic [INTENS_W-1:0] intensity;
   } item_type;

   function automatic logic signed [ZW-1:0] atan_at(input int i);
      logic signed [ZW-1:0] t;
      begin
         case (i)
            0: t = 34'sh020000000;
            1: t = 34'sh012E4051E;
            2: t = 34'sh009FB385B;
            3: t = 34'sh0051111D4;
            4: t = 34'sh0028B0D43;
            5: t = 34'sh00145D7E1;
            6: t = 34'sh000A2F61E;
            7: t = 34'sh000517C55;
            8: t = 34'sh00028BE53;
            9: t = 34'sh000145F2F;
            10: t = 34'sh0000A2F98;
            11: t = 34'sh0000517CC;
            12: t = 34'sh000028BE6;
            13: t = 34'sh0000145F3;
            14: t = 34'sh000000A2FA;
            15: t = 34'sh00000517D;
            default: t = '0;
         endcase
         return t;
      end
   endfunction

endpackage

// File: sv/lrp_front.sv
// ----------------------------------------------------------------------------
// lrp_front
// register file, range window check and angle computation, one sample a cycle
// ----------------------------------------------------------------------------
module lrp_front #(
   parameter int MAX_COLUMNS = lrp_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = lrp_pkg::DEF_MAX_ROWS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [lrp_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [lrp_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               in_valid,
   input  logic [lrp_pkg::RANGE_W-1:0]        range_mm,
   input  logic                               range_finite,
   input  logic [lrp_pkg::COLUMN_W-1:0]       column,
   input  logic [lrp_pkg::ROW_W-1:0]          row,
   input  logic                               scan_end,
   output logic                               out_valid,
   output lrp_pkg::item_type                  out_item
);
   import lrp_pkg::*;

   logic [ANGLE_W-1:0]  hstart_ff, hstep_ff, vstart_ff, vstep_ff, intens_ff;
   logic [RANGE_W-1:0]  rlow_ff, rhigh_ff;
   logic                valid_ff;
   item_type            item_ff, item_in;
   logic [COLUMN_W+ANGLE_W-1:0] hprod;
   logic [ROW_W+ANGLE_W-1:0]    vprod;
   logic                col_ok, row_ok;

   always_comb begin
      hprod   = column * hstep_ff;
      vprod   = row * vstep_ff;
      col_ok  = ({21'd0, column} < 32'(MAX_COLUMNS));
      row_ok  = ({25'd0, row} < 32'(MAX_ROWS));
      item_in.range_mm  = range_mm;
      item_in.h_angle   = hstart_ff + hprod[ANGLE_W-1:0];
      item_in.v_angle   = vstart_ff + vprod[ANGLE_W-1:0];
      item_in.row       = row;
      item_in.kept      = range_finite && (range_mm >= rlow_ff) && (range_mm <= rhigh_ff)
                          && col_ok && row_ok;
      item_in.last      = scan_end;
      item_in.intensity = intens_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hstart_ff <= '0;
         hstep_ff  <= '0;
         vstart_ff <= '0;
         vstep_ff  <= '0;
         rlow_ff   <= '0;
         rhigh_ff  <= '1;
         intens_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= in_valid;
         if (csr_valid) begin
            case (csr_index)
               REG_HSTART: hstart_ff <= csr_data[ANGLE_W-1:0];
               REG_HSTEP:  hstep_ff  <= csr_data[ANGLE_W-1:0];
               REG_VSTART: vstart_ff <= csr_data[ANGLE_W-1:0];
               REG_VSTEP:  vstep_ff  <= csr_data[ANGLE_W-1:0];
               REG_RLOW:   rlow_ff   <= csr_data;
               REG_RHIGH:  rhigh_ff  <= csr_data;
               REG_INTENS: intens_ff <= csr_data[ANGLE_W-1:0];
               default: ;
            endcase
         end
      end
      if (in_valid) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: sv/lrp_queue.sv
// ----------------------------------------------------------------------------
// lrp_queue
// short register queue between the front and the back, two entries
// ----------------------------------------------------------------------------
module lrp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lrp_pkg::item_type push_item,
   output logic              pop_valid,
   output lrp_pkg::item_type pop_item,
   input  logic              pop
);
   import lrp_pkg::*;

   item_type mem_ff [2];
   logic     wr_ff, rd_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop && pop_valid) rd_ff <= ~rd_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop && pop_valid);
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

   assign pop_valid = (count_ff != 2'd0);
   assign pop_item  = mem_ff[rd_ff];

endmodule

// File: sv/lrp_cordic.sv
// ----------------------------------------------------------------------------
// lrp_cordic
// pipelined sixteen stage rotation giving q15 sine and cosine of a binary angle
// ----------------------------------------------------------------------------
module lrp_cordic (
   input  logic                              clock,
   input  logic [lrp_pkg::ANGLE_W-1:0]       angle,
   output logic signed [lrp_pkg::ANGLE_W:0]  sin_q15,
   output logic signed [lrp_pkg::ANGLE_W:0]  cos_q15
);
   import lrp_pkg::*;

   logic signed [CW-1:0] x_ff [STAGES+1];
   logic signed [CW-1:0] y_ff [STAGES+1];
   logic signed [ZW-1:0] z_ff [STAGES+1];
   logic                 flip_ff [STAGES+1];
   logic [ANGLE_W-1:0]   a_fold;
   logic signed [CW-1:0] xo, yo;
   logic signed [CW:0]   xr, yr;

   assign a_fold = angle ^ {angle[15] ^ angle[14], 15'd0};

   always_ff @(posedge clock) begin
      x_ff[0]    <= CORDIC_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= {{(ZW-32){a_fold[15]}}, a_fold, 16'd0};
      flip_ff[0] <= angle[15] ^ angle[14];
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         flip_ff[i+1] <= flip_ff[i];
         if (!z_ff[i][ZW-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_at(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_at(i);
         end
      end
   end

   always_comb begin
      xo = flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
      yo = flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
      xr = (CW+1)'(xo + 34'sd16384) >>> 15;
      yr = (CW+1)'(yo + 34'sd16384) >>> 15;
   end

   always_ff @(posedge clock) begin
      cos_q15 <= (xr > 32767) ? 17'sd32767 : (xr < -32767) ? -17'sd32767 : xr[ANGLE_W:0];
      sin_q15 <= (yr > 32767) ? 17'sd32767 : (yr < -32767) ? -17'sd32767 : yr[ANGLE_W:0];
   end

endmodule

// File: sv/lrp_back.sv
// ----------------------------------------------------------------------------
// lrp_back
// trig pipelines and the scaling multipliers that form the cartesian point
// ----------------------------------------------------------------------------
module lrp_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  lrp_pkg::item_type                     in_item,
   output logic                                  rsp_valid,
   output logic signed [lrp_pkg::COORD_W-1:0]    rsp_point_x,
   output logic signed [lrp_pkg::COORD_W-1:0]    rsp_point_y,
   output logic signed [lrp_pkg::COORD_W-1:0]    rsp_point_z,
   output logic [lrp_pkg::INTENS_W-1:0]          rsp_point_intensity,
   output logic [lrp_pkg::ROW_W-1:0]             rsp_ring_index,
   output logic                                  rsp_point_kept,
   output logic                                  rsp_scan_last
);
   import lrp_pkg::*;

   localparam int TRIG_LAT = STAGES + 2;
   localparam int LAT      = TRIG_LAT + 2;

   logic signed [ANGLE_W:0] sh, ch, sv, cv;
   logic                    v_ff [LAT];
   item_type                it_ff [LAT];
   logic signed [38:0]      rcv_ff, rsv_ff;
   logic signed [ANGLE_W:0] ch_ff, sh_ff;
   logic signed [55:0]      px_ff, py_ff;
   logic signed [38:0]      pz_ff;
   logic signed [55:0]      xs, ys;
   logic signed [38:0]      zs;

   lrp_cordic u_h (.clock(clock), .angle(in_item.h_angle), .sin_q15(sh), .cos_q15(ch));
   lrp_cordic u_v (.clock(clock), .angle(in_item.v_angle), .sin_q15(sv), .cos_q15(cv));

   always_ff @(posedge clock) begin
      it_ff[0] <= in_item;
      for (int i = 0; i < LAT-1; i++) it_ff[i+1] <= it_ff[i];
      if (reset) begin
         for (int i = 0; i < LAT; i++) v_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 0; i < LAT-1; i++) v_ff[i+1] <= v_ff[i];
      end
      rcv_ff <= $signed({19'd0, it_ff[TRIG_LAT-1].range_mm}) * 39'(cv);
      rsv_ff <= $signed({19'd0, it_ff[TRIG_LAT-1].range_mm}) * 39'(sv);
      ch_ff  <= ch;
      sh_ff  <= sh;
      px_ff  <= 56'(rcv_ff) * 56'(ch_ff);
      py_ff  <= 56'(rcv_ff) * 56'(sh_ff);
      pz_ff  <= rsv_ff;
   end

   always_comb begin
      xs = (px_ff + 56'sd536870912) >>> 30;
      ys = (py_ff + 56'sd536870912) >>> 30;
      zs = (pz_ff + 39'sd16384) >>> 15;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= v_ff[LAT-1];
      rsp_point_x         <= it_ff[LAT-1].kept ? xs[COORD_W-1:0] : '0;
      rsp_point_y         <= it_ff[LAT-1].kept ? ys[COORD_W-1:0] : '0;
      rsp_point_z         <= it_ff[LAT-1].kept ? zs[COORD_W-1:0] : '0;
      rsp_point_intensity <= it_ff[LAT-1].intensity;
      rsp_ring_index      <= it_ff[LAT-1].row;
      rsp_point_kept      <= it_ff[LAT-1].kept;
      rsp_scan_last       <= it_ff[LAT-1].last;
   end

endmodule

// File: sv/lidar_range_to_point.sv
// ----------------------------------------------------------------------------
// lidar_range_to_point
// lidar range sample to cartesian point conversion
// ----------------------------------------------------------------------------
// usage:
//   configuration beats arrive on csr_valid/csr_index/csr_data; csr_ready is
//   always high and a write lands at the edge where csr_valid is high.
//   a sample is taken at each edge with start high; busy is always low, so a
//   new sample may enter every cycle.
//   each sample yields exactly one result, shown for one cycle with rsp_valid;
//   results leave in sample order.
//   each result passes the front register, the queue, the sixteen stage
//   rotation pipeline and the two multiplier stages before its rsp_valid cycle.
//   throughput: one sample per cycle.
//   reset clears the registers to their defaults and empties the pipeline.
//   the receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module lidar_range_to_point #(
   parameter int MAX_COLUMNS = lrp_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = lrp_pkg::DEF_MAX_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lrp_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [lrp_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [lrp_pkg::RANGE_W-1:0]          req_range_mm,
   input  logic                                 req_range_finite,
   input  logic [lrp_pkg::COLUMN_W-1:0]         req_column,
   input  logic [lrp_pkg::ROW_W-1:0]            req_row,
   input  logic                                 req_scan_end,
   output logic                                 rsp_valid,
   output logic signed [lrp_pkg::COORD_W-1:0]   rsp_point_x,
   output logic signed [lrp_pkg::COORD_W-1:0]   rsp_point_y,
   output logic signed [lrp_pkg::COORD_W-1:0]   rsp_point_z,
   output logic [lrp_pkg::INTENS_W-1:0]         rsp_point_intensity,
   output logic [lrp_pkg::ROW_W-1:0]            rsp_ring_index,
   output logic                                 rsp_point_kept,
   output logic                                 rsp_scan_last
);
   import lrp_pkg::*;

   logic     f_valid, q_valid;
   item_type f_item, q_item;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   lrp_front #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .in_valid(start), .range_mm(req_range_mm), .range_finite(req_range_finite),
      .column(req_column), .row(req_row), .scan_end(req_scan_end),
      .out_valid(f_valid), .out_item(f_item)
   );

   lrp_queue u_queue (
      .clock(clock), .reset(reset),
      .push(f_valid), .push_item(f_item),
      .pop_valid(q_valid), .pop_item(q_item), .pop(1'b1)
   );

   lrp_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_item(q_item),
      .rsp_valid(rsp_valid), .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_point_z(rsp_point_z), .rsp_point_intensity(rsp_point_intensity),
      .rsp_ring_index(rsp_ring_index), .rsp_point_kept(rsp_point_kept),
      .rsp_scan_last(rsp_scan_last)
   );

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_kept |-> rsp_point_x == '0 && rsp_point_y == '0
      && rsp_point_z == '0) else $error("dropped point with coordinates");

   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      f_valid |=> q_valid) else $error("queue lost an item");

   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> $past(f_valid)) else $error("queue produced an item");

endmodule
